// ===== rtl/ihdp_pkg.sv =====
// ---------------------------------------------------------------------------
// ihdp_pkg
// shared types, codes and header tables of the image header dimension parser
// ---------------------------------------------------------------------------
package ihdp_pkg;

  // image format codes held in the format register
  localparam logic [2:0] FMT_PNG  = 3'd0;
  localparam logic [2:0] FMT_BMP  = 3'd1;
  localparam logic [2:0] FMT_DDS  = 3'd2;
  localparam logic [2:0] FMT_TGA  = 3'd3;
  localparam logic [2:0] FMT_JPEG = 3'd4;

  localparam int FMT_W = 3;

  // jpeg marker codes
  localparam logic [7:0] JPG_PREFIX = 8'hff;
  localparam logic [7:0] JPG_SOI    = 8'hd8;
  localparam logic [7:0] JPG_EOI    = 8'hd9;
  localparam logic [7:0] JPG_SOS    = 8'hda;
  localparam logic [7:0] JPG_SOF_LO = 8'hc0;
  localparam logic [7:0] JPG_SOF_HI = 8'hcf;
  localparam logic [7:0] JPG_DHT    = 8'hc4;
  localparam logic [7:0] JPG_JPG    = 8'hc8;
  localparam logic [7:0] JPG_DAC    = 8'hcc;

  // bmp signature
  localparam logic [7:0] BMP_SIG0 = 8'h42;
  localparam logic [7:0] BMP_SIG1 = 8'h4d;

  // position of the deciding byte for the fixed layouts
  localparam logic [4:0] PNG_LAST = 5'd23;
  localparam logic [4:0] BMP_LAST = 5'd25;
  localparam logic [4:0] DDS_LAST = 5'd19;
  localparam logic [4:0] TGA_LAST = 5'd17;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'd0,
    PH_SECOND = 3'd1,
    PH_PREFIX = 3'd2,
    PH_MARKER = 3'd3,
    PH_LEN_HI = 3'd4,
    PH_LEN_LO = 3'd5,
    PH_FRAME  = 3'd6,
    PH_SKIP   = 3'd7
  } ihdp_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } ihdp_in_t;

  typedef struct packed {
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic        size_ok;
  } ihdp_out_t;

  typedef struct packed {
    logic [4:0]  byte_position;
    ihdp_phase_t jpeg_phase;
    logic [15:0] skip_remaining;
    logic [7:0]  current_marker;
    logic [7:0]  length_high_byte;
    logic [31:0] width_acc;
    logic [31:0] height_acc;
    logic        result_given;
  } ihdp_state_t;

  function automatic logic [7:0] png_sig(input logic [2:0] idx);
    logic [7:0] v;
    unique case (idx)
      3'd0: v = 8'd137;
      3'd1: v = 8'd80;
      3'd2: v = 8'd78;
      3'd3: v = 8'd71;
      3'd4: v = 8'd13;
      3'd5: v = 8'd10;
      3'd6: v = 8'd26;
      3'd7: v = 8'd10;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] dds_sig(input logic [1:0] idx);
    logic [7:0] v;
    unique case (idx)
      2'd0: v = 8'h44;
      2'd1: v = 8'h44;
      2'd2: v = 8'h53;
      2'd3: v = 8'h20;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // little-endian byte placement into an accumulator
  function automatic logic [31:0] le_put(input logic [31:0] acc, input logic [7:0] b,
                                          input logic [1:0] k);
    return acc | ({24'd0, b} << {k, 3'b000});
  endfunction

  function automatic logic is_frame(input logic [7:0] m);
    return (m >= JPG_SOF_LO) && (m <= JPG_SOF_HI) &&
           (m != JPG_DHT) && (m != JPG_JPG) && (m != JPG_DAC);
  endfunction

endpackage

// ===== rtl/ihdp_step.sv =====
// ---------------------------------------------------------------------------
// ihdp_step
// per-byte next-state and result logic for all header formats
// ---------------------------------------------------------------------------
module ihdp_step (
  input  logic [2:0]          fmt,
  input  ihdp_pkg::ihdp_in_t  in_word,
  input  ihdp_pkg::ihdp_state_t cur,
  output ihdp_pkg::ihdp_state_t nxt,
  output logic                emit,
  output ihdp_pkg::ihdp_out_t res
);

  logic [7:0]  b;
  logic [4:0]  p;
  logic        decided;
  logic        ok;
  logic [4:0]  last_pos;
  logic [4:0]  off;
  logic [15:0] seg_len;

  assign b = in_word.data_byte;
  assign p = cur.byte_position;

  always_comb begin
    nxt      = cur;
    decided  = 1'b0;
    ok       = 1'b0;
    last_pos = 5'd0;
    off      = 5'd0;
    seg_len  = {cur.length_high_byte, b};
    emit     = 1'b0;

    if (!cur.result_given) begin
      if (fmt == ihdp_pkg::FMT_JPEG) begin
        unique case (cur.jpeg_phase)
          ihdp_pkg::PH_FIRST: begin
            if (b != ihdp_pkg::JPG_PREFIX) decided = 1'b1;
            else nxt.jpeg_phase = ihdp_pkg::PH_SECOND;
          end
          ihdp_pkg::PH_SECOND: begin
            if (b != ihdp_pkg::JPG_SOI) decided = 1'b1;
            else nxt.jpeg_phase = ihdp_pkg::PH_PREFIX;
          end
          ihdp_pkg::PH_PREFIX: begin
            if (b == ihdp_pkg::JPG_PREFIX) nxt.jpeg_phase = ihdp_pkg::PH_MARKER;
          end
          ihdp_pkg::PH_MARKER: begin
            priority if (b == ihdp_pkg::JPG_PREFIX) begin
              // fill byte
            end else if (b == ihdp_pkg::JPG_EOI || b == ihdp_pkg::JPG_SOS) begin
              decided = 1'b1;
            end else begin
              nxt.current_marker = b;
              nxt.jpeg_phase     = ihdp_pkg::PH_LEN_HI;
            end
          end
          ihdp_pkg::PH_LEN_HI: begin
            nxt.length_high_byte = b;
            nxt.jpeg_phase       = ihdp_pkg::PH_LEN_LO;
          end
          ihdp_pkg::PH_LEN_LO: begin
            priority if (seg_len < 16'd2) begin
              decided = 1'b1;
            end else if (ihdp_pkg::is_frame(cur.current_marker)) begin
              nxt.byte_position = 5'd0;
              nxt.width_acc     = 32'd0;
              nxt.height_acc    = 32'd0;
              nxt.jpeg_phase    = ihdp_pkg::PH_FRAME;
            end else begin
              nxt.skip_remaining = seg_len - 16'd2;
              nxt.jpeg_phase     = (seg_len == 16'd2) ? ihdp_pkg::PH_PREFIX
                                                      : ihdp_pkg::PH_SKIP;
            end
          end
          ihdp_pkg::PH_FRAME: begin
            if (p == 5'd1 || p == 5'd2) nxt.height_acc = {16'd0, cur.height_acc[7:0], b};
            if (p == 5'd3 || p == 5'd4) nxt.width_acc  = {16'd0, cur.width_acc[7:0], b};
            if (p >= 5'd4) begin
              decided = 1'b1;
              ok      = (nxt.width_acc != 32'd0) && (nxt.height_acc != 32'd0);
            end else begin
              nxt.byte_position = p + 5'd1;
            end
          end
          ihdp_pkg::PH_SKIP: begin
            nxt.skip_remaining = cur.skip_remaining - 16'd1;
            if (cur.skip_remaining == 16'd1) nxt.jpeg_phase = ihdp_pkg::PH_PREFIX;
          end
          default: nxt.jpeg_phase = ihdp_pkg::PH_PREFIX;
        endcase
      end else begin
        unique case (fmt)
          ihdp_pkg::FMT_PNG: begin
            last_pos = ihdp_pkg::PNG_LAST;
            if (p < 5'd8 && b != ihdp_pkg::png_sig(p[2:0])) decided = 1'b1;
            if (p >= 5'd16 && p < 5'd20) nxt.width_acc  = {cur.width_acc[23:0], b};
            if (p >= 5'd20 && p < 5'd24) nxt.height_acc = {cur.height_acc[23:0], b};
          end
          ihdp_pkg::FMT_BMP: begin
            last_pos = ihdp_pkg::BMP_LAST;
            if (p == 5'd0 && b != ihdp_pkg::BMP_SIG0) decided = 1'b1;
            if (p == 5'd1 && b != ihdp_pkg::BMP_SIG1) decided = 1'b1;
            if (p >= 5'd18 && p < 5'd22) begin
              off = p - 5'd18;
              nxt.width_acc = ihdp_pkg::le_put(cur.width_acc, b, off[1:0]);
            end
            if (p >= 5'd22 && p < 5'd26) begin
              off = p - 5'd22;
              nxt.height_acc = ihdp_pkg::le_put(cur.height_acc, b, off[1:0]);
            end
          end
          ihdp_pkg::FMT_DDS: begin
            last_pos = ihdp_pkg::DDS_LAST;
            if (p < 5'd4 && b != ihdp_pkg::dds_sig(p[1:0])) decided = 1'b1;
            if (p >= 5'd12 && p < 5'd16) begin
              off = p - 5'd12;
              nxt.height_acc = ihdp_pkg::le_put(cur.height_acc, b, off[1:0]);
            end
            if (p >= 5'd16 && p < 5'd20) begin
              off = p - 5'd16;
              nxt.width_acc = ihdp_pkg::le_put(cur.width_acc, b, off[1:0]);
            end
          end
          ihdp_pkg::FMT_TGA: begin
            last_pos = ihdp_pkg::TGA_LAST;
            if (p >= 5'd12 && p < 5'd14) begin
              off = p - 5'd12;
              nxt.width_acc = ihdp_pkg::le_put(cur.width_acc, b, off[1:0]);
            end
            if (p >= 5'd14 && p < 5'd16) begin
              off = p - 5'd14;
              nxt.height_acc = ihdp_pkg::le_put(cur.height_acc, b, off[1:0]);
            end
          end
          default: decided = 1'b1; // unknown format code fails at once
        endcase

        if (!decided) begin
          if (p >= last_pos) begin
            decided = 1'b1;
            ok      = (nxt.width_acc != 32'd0) && (nxt.height_acc != 32'd0);
          end else begin
            nxt.byte_position = p + 5'd1;
          end
        end
      end

      emit = decided || in_word.last_byte;
      if (emit) nxt.result_given = 1'b1;
    end

    res.image_width  = ok ? nxt.width_acc  : 32'd0;
    res.image_height = ok ? nxt.height_acc : 32'd0;
    res.size_ok      = ok;

    // final byte rearms the parser
    if (in_word.last_byte) nxt = '0;
  end

endmodule

// ===== rtl/image_header_dimension_parser.sv =====
// ---------------------------------------------------------------------------
// image_header_dimension_parser
// streams image file bytes and reports width and height from the header
// ---------------------------------------------------------------------------
//  channel | direction | handshake        | word
//  --------+-----------+------------------+------------------------------------
//  in_     | input     | in_valid/in_stall   | data_byte, last_byte
//  out_    | output    | out_valid/out_stall | image_width, image_height, size_ok
//  cfg_    | input     | cfg_valid/cfg_ready | image format code (3 bits)
//
//  one byte is accepted per cycle while in_stall is low; a byte is held in
//  the input register and its result, if any, is then written to the output
//  register once the result register can take it
//  at most one result per file, on the deciding byte or on the final byte
//  rst_n is synchronous, active low; it clears the parse state and the format
//  out_stall holds the result register and, once it is full, the input
//  register, which then raises in_stall
//  cfg_ready is always high; a new format applies to the next byte parsed
// ---------------------------------------------------------------------------
module image_header_dimension_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  // byte stream
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ihdp_pkg::ihdp_in_t   in_word,
  // results
  output logic                 out_valid,
  input  logic                 out_stall,
  output ihdp_pkg::ihdp_out_t  out_word,
  // format register write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [ihdp_pkg::FMT_W-1:0] cfg_data
);

  // input register
  logic                  in_valid_r;
  ihdp_pkg::ihdp_in_t    in_word_r;

  // parse state and format register
  ihdp_pkg::ihdp_state_t state_r;
  ihdp_pkg::ihdp_state_t state_nxt;
  logic [ihdp_pkg::FMT_W-1:0] fmt_r;

  // result register
  logic                  out_valid_r;
  ihdp_pkg::ihdp_out_t   out_word_r;

  logic                  proc;
  logic                  emit;
  ihdp_pkg::ihdp_out_t   res;

  // the held byte is parsed once the result register can take a result
  assign proc      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !proc;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  ihdp_step u_step (
    .fmt     (fmt_r),
    .in_word (in_word_r),
    .cur     (state_r),
    .nxt     (state_nxt),
    .emit    (emit),
    .res     (res)
  );

  // input register: refilled whenever it empties or is being parsed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (proc) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_word_r <= in_word;
    end
  end

  // parse state advances once per parsed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (proc) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= ihdp_pkg::FMT_PNG;
    end else if (cfg_valid && cfg_ready) begin
      fmt_r <= cfg_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      out_word_r <= res;
    end
  end

endmodule

// ===== rtl/ihdp_checker.sv =====
// ---------------------------------------------------------------------------
// ihdp_checker
// port-level checks of the image header dimension parser
// ---------------------------------------------------------------------------
module ihdp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input ihdp_pkg::ihdp_in_t  in_word,
  input logic                out_valid,
  input logic                out_stall,
  input ihdp_pkg::ihdp_out_t out_word
);

  // stalled byte holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_word))
    else $error("input word changed while stalled");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result changed while stalled");

  // failure carries zero dimensions
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.size_ok |->
      out_word.image_width == 32'd0 && out_word.image_height == 32'd0)
    else $error("failure result with nonzero dimensions");

  // success carries nonzero dimensions
  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.size_ok |->
      out_word.image_width != 32'd0 && out_word.image_height != 32'd0)
    else $error("ok result with a zero dimension");

  // input only backs up behind a stalled full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

endmodule

bind image_header_dimension_parser ihdp_checker u_ihdp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
